FILE: src/trht_pkg.sv
// Package for the TLS record header tracker.
// Holds codes, config and result types shared by the tracker core and the top level.
// No dependencies.
package trht_pkg;

    localparam int unsigned HDR_LEN       = 5;
    localparam int unsigned CFG_IDX_W     = 8;
    localparam int unsigned CFG_DATA_W    = 17;
    localparam int unsigned LEN_W         = 17;
    localparam int unsigned PAYLOAD_W     = 16;
    localparam int unsigned COUNT_W       = 64;
    localparam int unsigned POS_W         = 3;
    localparam int unsigned S_TDATA_W     = 8;
    localparam int unsigned M_TDATA_W     = 96;
    localparam int unsigned M_TUSER_W     = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAJOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RECORD    = 8'd3;

    localparam logic [7:0]       VERSION_RESET     = 8'd3;
    localparam logic [15:0]      MAX_PAYLOAD_RESET = 16'd16384;
    localparam logic [LEN_W-1:0] MIN_RECORD_RESET  = 17'd29;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_BODY    = 2'd1,
        KIND_DISCARD = 2'd2
    } byte_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_VER   = 2'd1,
        STATUS_TOO_LONG  = 2'd2,
        STATUS_TOO_SHORT = 2'd3
    } hdr_status_t;

    typedef struct packed {
        logic [7:0]           version_major;
        logic [7:0]           version_minor;
        logic [PAYLOAD_W-1:0] max_payload;
        logic [LEN_W-1:0]     min_record;
    } cfg_t;

    // result of one stream byte
    typedef struct packed {
        byte_kind_t           byte_kind;
        logic                 header_complete;
        hdr_status_t          header_status;
        logic [7:0]           content_type;
        logic [LEN_W-1:0]     record_length;
        logic [COUNT_W-1:0]   record_number;
    } result_t;

endpackage

FILE: src/tls_record_header_tracker.sv
// Top level of the TLS record header tracker: config registers, core and output skid.
// Depends on trht_pkg, trht_tracker and trht_skid.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | one stream byte, realign flag in s_tuser
//  m_      | out       | m_tvalid/m_tready  | one result per byte, byte kind in m_tuser
//  cfg_    | in        | cfg_wr_en          | register index and write data, no read
//
// One byte is taken every cycle while s_tready is high; its result, from a single pass
// of framing logic, is registered in the output register, or in the skid stage while
// the output is held. Reset (aresetn low, synchronous) restores the default config and
// clears all framing state. When m_tready drops, one extra result lands in the skid
// stage and s_tready falls the next cycle; it rises again once the skid drains.
module tls_record_header_tracker
    import trht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] realign

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] header_complete, [2:1] header_status, [10:3] content_type,
    // [27:11] record_length, [91:28] record_number, [95:92] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] byte_kind

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    logic    s_ready;
    logic    accept;
    result_t core_result;
    result_t out_result;

    // Config writes; an index past the last register is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.version_major <= VERSION_RESET;
            cfg_reg.version_minor <= VERSION_RESET;
            cfg_reg.max_payload   <= MAX_PAYLOAD_RESET;
            cfg_reg.min_record    <= MIN_RECORD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_VERSION_MAJOR: cfg_reg.version_major <= cfg_wdata[7:0];
                CFG_VERSION_MINOR: cfg_reg.version_minor <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD:   cfg_reg.max_payload   <= cfg_wdata[PAYLOAD_W-1:0];
                CFG_MIN_RECORD:    cfg_reg.min_record    <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = s_ready;
    assign accept   = s_tvalid && s_ready;

    // framing state advances on each accepted request
    trht_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata[7:0]),
        .realign   (s_tuser),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    trht_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tuser = out_result.byte_kind;
    assign m_tdata = {4'b0000,
                      out_result.record_number,
                      out_result.record_length,
                      out_result.content_type,
                      out_result.header_status,
                      out_result.header_complete};

endmodule

FILE: src/trht_tracker.sv
// Record framing core: header capture, header checks, body skip and record count.
// Computes one result per accepted byte in a single pass. Depends on trht_pkg.
module trht_tracker
    import trht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       realign,
    input  cfg_t       cfg,
    output result_t    result
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           store_reg [4];
    logic [7:0]           store_next [4];
    logic [PAYLOAD_W-1:0] remain_reg, remain_next;
    logic                 in_body_reg, in_body_next;
    logic                 halted_reg, halted_next;
    logic [COUNT_W-1:0]   seen_reg, seen_next;

    // state as seen after a realign on this byte
    logic [POS_W-1:0]     pos_eff;
    logic [PAYLOAD_W-1:0] remain_eff;
    logic                 in_body_eff;
    logic                 halted_eff;

    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     length;
    hdr_status_t          status;

    assign pos_eff     = realign ? '0 : pos_reg;
    assign remain_eff  = realign ? '0 : remain_reg;
    assign in_body_eff = realign ? 1'b0 : in_body_reg;
    assign halted_eff  = realign ? 1'b0 : halted_reg;

    assign payload = {store_reg[3], data_byte};
    assign length  = {1'b0, payload} + LEN_W'(HDR_LEN);

    // bad version wins, then too long, then too short
    always_comb begin
        if (store_reg[1] != cfg.version_major || store_reg[2] != cfg.version_minor) begin
            status = STATUS_BAD_VER;
        end else if (payload > cfg.max_payload) begin
            status = STATUS_TOO_LONG;
        end else if (length < cfg.min_record) begin
            status = STATUS_TOO_SHORT;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        pos_next     = pos_eff;
        remain_next  = remain_eff;
        in_body_next = in_body_eff;
        halted_next  = halted_eff;
        seen_next    = seen_reg;
        for (int i = 0; i < 4; i++) begin
            store_next[i] = store_reg[i];
        end
        result.byte_kind       = KIND_HEADER;
        result.header_complete = 1'b0;
        result.header_status   = STATUS_OK;
        result.record_length   = '0;

        if (halted_eff) begin
            result.byte_kind = KIND_DISCARD;
        end else if (in_body_eff) begin
            result.byte_kind = KIND_BODY;
            remain_next      = remain_eff - PAYLOAD_W'(1);
            in_body_next     = (remain_next != '0);
        end else if (!pos_eff[2]) begin
            store_next[pos_eff[1:0]] = data_byte;
            pos_next                 = pos_eff + POS_W'(1);
        end else begin
            // fifth header byte (or a stray position): run the checks
            result.header_complete = 1'b1;
            result.header_status   = status;
            result.record_length   = length;
            pos_next               = '0;
            if (status == STATUS_OK) begin
                seen_next    = seen_reg + COUNT_W'(1);
                remain_next  = payload;
                in_body_next = (payload != '0);
            end else begin
                halted_next = 1'b1;
            end
        end

        result.content_type  = store_next[0];
        result.record_number = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            remain_reg  <= '0;
            in_body_reg <= 1'b0;
            halted_reg  <= 1'b0;
            seen_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                store_reg[i] <= '0;
            end
        end else if (accept) begin
            pos_reg     <= pos_next;
            remain_reg  <= remain_next;
            in_body_reg <= in_body_next;
            halted_reg  <= halted_next;
            seen_reg    <= seen_next;
            for (int i = 0; i < 4; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

FILE: src/trht_skid.sv
// Result register with a skid stage, so input ready never waits on m_tready.
// Depends on trht_pkg for the result type.
module trht_skid
    import trht_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = in_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: test/tb.sv
// Testbench for tls_record_header_tracker: drives a byte stream of TLS-style records
// and checks every per-byte result against an in-bench framing tracker.
// Depends on trht_pkg and the RTL under src/.
module tb;
    import trht_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int unsigned HOLD_CYCLES  = 150;   // receiver hold-off in the pressure test
    localparam int unsigned PHASE_ITEMS  = 230;
    localparam int unsigned MAX_PRINTED  = 40;

    // indexes that hit no register; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hff;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tuser   = 1'b0; // [0] realign
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [0] header_complete, [2:1] header_status, [10:3] content_type,
    // [27:11] record_length, [91:28] record_number, [95:92] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;          // [1:0] byte_kind
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    tls_record_header_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Framing tracker mirror: config copy and per-connection state
    // ---------------------------------------------------------------
    logic [7:0]       set_major       = VERSION_RESET;
    logic [7:0]       set_minor       = VERSION_RESET;
    logic [15:0]      set_max_payload = MAX_PAYLOAD_RESET;
    logic [LEN_W-1:0] set_min_record  = MIN_RECORD_RESET;

    logic [POS_W-1:0]     rx_pos       = '0;
    logic [7:0]           rx_hdr [4]   = '{default: 8'h00};
    logic [15:0]          rx_body_left = '0;
    logic                 rx_in_body   = 1'b0;
    logic                 rx_halted    = 1'b0;
    logic [COUNT_W-1:0]   rx_records   = '0;

    result_t     pending_results [$];
    int unsigned n_sent     = 0;
    int unsigned n_results  = 0;
    int unsigned n_mismatch = 0;

    logic src_idle_en  = 1'b1;
    logic sink_idle_en = 1'b1;
    logic hold_active  = 1'b0;
    event hold_go;

    // Advance the tracker by one stream byte and return what the block should say.
    function automatic result_t track_byte(input logic [7:0] data, input logic realign);
        result_t          r;
        logic [15:0]      payload;
        logic [LEN_W-1:0] total;
        r = '0;
        r.byte_kind     = KIND_HEADER;
        r.header_status = STATUS_OK;
        // realign restarts header capture whatever the block was doing
        if (realign) begin
            rx_halted    = 1'b0;
            rx_in_body   = 1'b0;
            rx_body_left = '0;
            rx_pos       = '0;
        end
        if (rx_halted) begin
            r.byte_kind = KIND_DISCARD;
        end else if (rx_in_body) begin
            r.byte_kind  = KIND_BODY;
            rx_body_left = rx_body_left - 16'd1;
            if (rx_body_left == 16'd0)
                rx_in_body = 1'b0;
        end else if (rx_pos < POS_W'(4)) begin
            rx_hdr[rx_pos[1:0]] = data;
            rx_pos              = rx_pos + POS_W'(1);
        end else begin
            // fifth header byte: low length byte, run the checks
            payload           = {rx_hdr[3], data};
            total             = LEN_W'(payload) + LEN_W'(HDR_LEN);
            r.header_complete = 1'b1;
            r.record_length   = total;
            // priority: version, then too long, then too short
            if (rx_hdr[1] != set_major || rx_hdr[2] != set_minor)
                r.header_status = STATUS_BAD_VER;
            else if (payload > set_max_payload)
                r.header_status = STATUS_TOO_LONG;
            else if (total < set_min_record)
                r.header_status = STATUS_TOO_SHORT;
            rx_pos = '0;
            if (r.header_status == STATUS_OK) begin
                rx_records   = rx_records + COUNT_W'(1);
                rx_body_left = payload;
                rx_in_body   = (payload != 16'd0);
            end else begin
                rx_halted = 1'b1;
            end
        end
        r.content_type  = rx_hdr[0];
        r.record_number = rx_records;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] data, input logic realign);
        while (src_idle_en && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= realign;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(track_byte(data, realign));
        n_sent++;
    endtask

    task automatic push_header(input logic realign, input logic [7:0] ctype,
                               input logic [7:0] vmaj, input logic [7:0] vmin,
                               input logic [15:0] plen);
        push_byte(ctype, realign);
        push_byte(vmaj, 1'b0);
        push_byte(vmin, 1'b0);
        push_byte(plen[15:8], 1'b0);
        push_byte(plen[7:0], 1'b0);
    endtask

    // drop valid and let every outstanding result come back
    task automatic finish_burst();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Only called while idle. Mirror masks to register width like the block does.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_VERSION_MAJOR: set_major       = value[7:0];
            CFG_VERSION_MINOR: set_minor       = value[7:0];
            CFG_MAX_PAYLOAD:   set_max_payload = value[15:0];
            CFG_MIN_RECORD:    set_min_record  = value[LEN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // One record with random content; mostly well formed, some broken on purpose.
    task automatic send_record();
        int unsigned pick, lo, hi, plen, cut, body_n;
        logic        realign, good_ok;
        logic [7:0]  hdr [5];
        pick    = $urandom_range(99);
        lo      = (set_min_record > HDR_LEN) ? set_min_record - HDR_LEN : 0;
        hi      = set_max_payload;
        good_ok = (lo <= hi) && (lo <= 64);
        // halted or mid-record: the next header has to be marked
        realign = rx_halted || rx_in_body || (rx_pos != 0) || ($urandom_range(3) == 0);

        if (pick < 6) begin
            // raw noise, random realign marks
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom), ($urandom_range(3) == 0));
            return;
        end

        plen   = good_ok ? $urandom_range(lo, (hi < lo + 12) ? hi : lo + 12)
                         : $urandom_range(16);
        hdr[0] = 8'($urandom);
        hdr[1] = set_major;
        hdr[2] = set_minor;
        if (pick < 14) begin
            if (pick == 6 || $urandom_range(1))
                hdr[1] = hdr[1] ^ (8'd1 << $urandom_range(7));
            if (pick == 6 || hdr[1] == set_major)
                hdr[2] = hdr[2] ^ (8'd1 << $urandom_range(7));
        end else if (pick < 20 && hi < 65535) begin
            plen = hi + 1;
        end else if (pick < 26 && lo > 0 && lo <= 65536) begin
            plen = $urandom_range(0, lo - 1);
        end
        hdr[3] = plen[15:8];
        hdr[4] = plen[7:0];

        // partial header, abandoned by the next realign
        cut = (pick >= 26 && pick < 30) ? $urandom_range(1, 4) : 5;
        for (int i = 0; i < cut; i++)
            push_byte(hdr[i], (i == 0) ? realign : 1'b0);
        if (cut != 5)
            return;

        body_n = rx_in_body ? rx_body_left : 0;
        if (pick >= 30 && pick < 34 && body_n > 0)
            body_n = $urandom_range(0, body_n - 1);   // cut the body short
        repeat (body_n)
            push_byte(8'($urandom), 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Result side: check, then decide ready for the next cycle
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log readable if something breaks wholesale
        if (n_mismatch < MAX_PRINTED)
            $display("result %0d: %s got 0x%0h, expected 0x%0h", n_results, what, got, want);
        n_mismatch++;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", m_tdata[63:0], '0);
        end else begin
            want = pending_results.pop_front();
            if (m_tuser !== want.byte_kind)
                report_mismatch("byte_kind", 64'(m_tuser), 64'(want.byte_kind));
            if (m_tdata[0] !== want.header_complete)
                report_mismatch("header_complete", 64'(m_tdata[0]),
                                64'(want.header_complete));
            if (m_tdata[2:1] !== want.header_status)
                report_mismatch("header_status", 64'(m_tdata[2:1]),
                                64'(want.header_status));
            if (m_tdata[10:3] !== want.content_type)
                report_mismatch("content_type", 64'(m_tdata[10:3]), 64'(want.content_type));
            if (m_tdata[27:11] !== want.record_length)
                report_mismatch("record_length", 64'(m_tdata[27:11]),
                                64'(want.record_length));
            if (m_tdata[91:28] !== want.record_number)
                report_mismatch("record_number", m_tdata[91:28], want.record_number);
            if (m_tdata[95:92] !== 4'd0)
                report_mismatch("tdata pad bits", 64'(m_tdata[95:92]), '0);
        end
        n_results++;
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            check_result();
        if (hold_active)
            m_tready <= 1'b0;
        else if (sink_idle_en)
            m_tready <= ($urandom_range(99) >= 10);
        else
            m_tready <= 1'b1;
    end

    // long receiver hold-off, timed here so the sender keeps pushing meanwhile
    initial forever begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // any handshake on either side counts as progress
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tls_record_header_tracker: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset config: too short, discard while halted, realign, mid-body realign
    task automatic test_default_limits();
        push_header(1'b0, 8'h16, 8'd3, 8'd3, 16'd23);     // total 28, one below min
        push_byte(8'h2a, 1'b0);                           // halted: discarded
        push_header(1'b1, 8'h17, 8'd3, 8'd3, 16'd16384);  // largest allowed payload
        // realign inside that body; version and length both bad, version wins
        push_header(1'b1, 8'h00, 8'd2, 8'd3, 16'd16385);
        finish_burst();
    endtask

    // register masking, ignored indexes, empty payload, error priority, huge min
    task automatic test_register_extremes();
        write_reg(CFG_VERSION_MAJOR, 17'h1feff);   // upper bits dropped
        write_reg(CFG_VERSION_MINOR, 17'h1ff00);
        write_reg(CFG_MAX_PAYLOAD,   17'h10000);   // lands as 0
        write_reg(CFG_MIN_RECORD,    17'd5);
        write_reg(CFG_IDX_UNUSED,    17'd0);
        write_reg(CFG_IDX_TOP,       17'h1ffff);
        push_header(1'b1, 8'h80, 8'hff, 8'h00, 16'd0);    // empty payload, ok
        push_header(1'b0, 8'hff, 8'hff, 8'h00, 16'd1);    // too long
        finish_burst();
        write_reg(CFG_MIN_RECORD, 17'h1ffff);
        push_header(1'b1, 8'h01, 8'hff, 8'h00, 16'd1);    // too long beats too short
        finish_burst();
        write_reg(CFG_MAX_PAYLOAD, 17'h0ffff);
        write_reg(CFG_MIN_RECORD,  17'd65541);
        push_header(1'b1, 8'h7f, 8'hff, 8'h00, 16'hffff); // longest record still short
        finish_burst();
    endtask

    task automatic set_phase_config(input int phase);
        case (phase)
            0: begin
                write_reg(CFG_VERSION_MAJOR, CFG_DATA_W'(VERSION_RESET));
                write_reg(CFG_VERSION_MINOR, CFG_DATA_W'(VERSION_RESET));
                write_reg(CFG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(40)));
                write_reg(CFG_MIN_RECORD, CFG_DATA_W'($urandom_range(30)));
            end
            1: begin
                write_reg(CFG_VERSION_MAJOR, 17'h00);
                write_reg(CFG_VERSION_MINOR, 17'hff);
                write_reg(CFG_MAX_PAYLOAD, 17'h0ffff);
                write_reg(CFG_MIN_RECORD, 17'd0);
            end
            2: begin
                // only empty records pass
                write_reg(CFG_VERSION_MAJOR, CFG_DATA_W'($urandom_range(255)));
                write_reg(CFG_VERSION_MINOR, CFG_DATA_W'($urandom_range(255)));
                write_reg(CFG_MAX_PAYLOAD, 17'd0);
                write_reg(CFG_MIN_RECORD, 17'd0);
            end
            3: begin
                // nothing passes the length floor
                write_reg(CFG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(40)));
                write_reg(CFG_MIN_RECORD, 17'h1ffff);
            end
            4: begin
                // exactly one good payload length
                write_reg(CFG_MAX_PAYLOAD, 17'd1);
                write_reg(CFG_MIN_RECORD, 17'd6);
            end
            default: begin
                write_reg(CFG_VERSION_MAJOR, CFG_DATA_W'($urandom_range(255)));
                write_reg(CFG_VERSION_MINOR, CFG_DATA_W'($urandom_range(255)));
                write_reg(CFG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(48)));
                write_reg(CFG_MIN_RECORD, CFG_DATA_W'($urandom_range(60)));
            end
        endcase
    endtask

    task automatic test_random_records(input int first_phase, input int last_phase);
        int unsigned stop_at;
        for (int p = first_phase; p <= last_phase; p++) begin
            set_phase_config(p);
            // phase 1 runs with no idling on either side
            src_idle_en  <= (p != 1);
            sink_idle_en <= (p != 1);
            stop_at = n_sent + PHASE_ITEMS;
            while (n_sent < stop_at)
                send_record();
            finish_burst();
        end
        src_idle_en  <= 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        int unsigned stop_at;
        set_phase_config(0);
        src_idle_en <= 1'b0;
        -> hold_go;
        stop_at = n_sent + 160;
        while (n_sent < stop_at)
            send_record();
        finish_burst();
        src_idle_en <= 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_limits();
        test_register_extremes();
        test_random_records(0, 2);
        test_output_backpressure();
        test_random_records(3, 6);

        repeat (8) @(posedge aclk);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("tls_record_header_tracker: match");
        else
            $display("tls_record_header_tracker: mismatch");
        $finish;
    end

endmodule
